[sv/fssd_pkg.sv]
// Package for the friction stick status detector.
// Holds the status encoding, register indexes and shared structs.
// No dependencies.
`timescale 1ns / 1ps

package fssd_pkg;

    // Stick status encoding
    typedef enum logic [1:0] {
        ST_ADHERE  = 2'd0,
        ST_RISING  = 2'd1,
        ST_FALLING = 2'd2
    } fssd_status_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_NULL_ERROR_THRESHOLD     = 3'd0;
    localparam logic [2:0] CFG_STILL_VELOCITY_THRESHOLD = 3'd1;
    localparam logic [2:0] CFG_HOME_BAND_UPPER          = 3'd2;
    localparam logic [2:0] CFG_HOME_BAND_LOWER          = 3'd3;
    localparam logic [2:0] CFG_STICK_ERROR_THRESHOLD    = 3'd4;
    localparam logic [2:0] CFG_SET_DELAY_TICKS          = 3'd5;
    localparam logic [2:0] CFG_RESET_DELAY_TICKS        = 3'd6;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // Thresholds used by the condition logic
    typedef struct packed {
        logic [15:0] null_error_threshold;
        logic [14:0] still_velocity_threshold;
        logic [15:0] home_band_upper;
        logic [15:0] home_band_lower;
        logic [15:0] stick_error_threshold;
    } fssd_thresh_t;

    // Conditions formed from one sample
    typedef struct packed {
        logic settled;
        logic rising;
        logic falling;
    } fssd_cond_t;

endpackage

[sv/fssd_cond.sv]
// Condition logic: settled, rising stick and falling stick from one sample.
// Depends on fssd_pkg.
`timescale 1ns / 1ps

module fssd_cond
(
    input  logic signed [15:0] position_error,
    input  logic signed [15:0] estimated_velocity,
    input  logic signed [15:0] home_distance,
    input  fssd_pkg::fssd_thresh_t thresh,
    output fssd_pkg::fssd_cond_t   cond
);

    logic [16:0]        err_mag;
    logic [16:0]        vel_mag;
    logic signed [17:0] err_w;
    logic signed [17:0] dist_w;
    logic signed [17:0] upper_w;
    logic signed [17:0] lower_neg_w;
    logic signed [17:0] stick_w;
    logic signed [17:0] stick_neg_w;
    logic               slow;
    logic               outside_band;
    logic               qualify;

    // Magnitudes over 17 bits so the most negative value does not wrap
    always_comb
    begin
        err_w = {{2{position_error[15]}}, position_error};
        if (position_error[15])
        begin
            err_mag = 17'(-({position_error[15], position_error}));
        end
        else
        begin
            err_mag = {1'b0, position_error};
        end
        if (estimated_velocity[15])
        begin
            vel_mag = 17'(-({estimated_velocity[15], estimated_velocity}));
        end
        else
        begin
            vel_mag = {1'b0, estimated_velocity};
        end
    end

    // Signed compares at 18 bits against the band and stick limits
    always_comb
    begin
        dist_w       = {{2{home_distance[15]}}, home_distance};
        upper_w      = {2'b00, thresh.home_band_upper};
        lower_neg_w  = -$signed({2'b00, thresh.home_band_lower});
        stick_w      = {2'b00, thresh.stick_error_threshold};
        stick_neg_w  = -$signed({2'b00, thresh.stick_error_threshold});
        slow         = vel_mag < {2'b00, thresh.still_velocity_threshold};
        outside_band = (dist_w > upper_w) || (dist_w < lower_neg_w);
        qualify      = slow && outside_band;
        cond.settled = err_mag < {1'b0, thresh.null_error_threshold};
        cond.rising  = qualify && (err_w > stick_w);
        cond.falling = qualify && (err_w < stick_neg_w);
    end

endmodule

[sv/friction_stick_status_detector_unit.sv]
// Top level of the friction stick status detector.
// Depends on fssd_pkg and fssd_cond.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  in       | in_valid/in_stall   | position_error, estimated_velocity,
//           |                     | home_distance
//  out      | out_valid/out_stall | stick_status, rising_enable,
//           |                     | falling_enable, settle_enable
//  cfg      | cfg_we              | cfg_index, cfg_data
//
// One word in, one word out, one word per cycle sustained while out_stall
// is low. A sample is registered on accept; its result is registered when
// the input register moves on, and the counters and status advance with it.
// Reset zeroes the config registers, valid flags, counts and status (adhere),
// not the payloads. An output stall holds the result and the input register;
// in_stall rises only when the input register is full and cannot move on.
`timescale 1ns / 1ps

module friction_stick_status_detector_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [15:0]                    position_error,
    input  logic signed [15:0]                    estimated_velocity,
    input  logic signed [15:0]                    home_distance,
    // output channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [1:0]                            stick_status,
    output logic                                  rising_enable,
    output logic                                  falling_enable,
    output logic                                  settle_enable,
    // configuration
    input  logic                                  cfg_we,
    input  logic [fssd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [fssd_pkg::CFG_DATA_W-1:0]       cfg_data
);

    fssd_pkg::fssd_thresh_t thresh_reg;
    logic [7:0]             set_delay_reg;
    logic [7:0]             reset_delay_reg;

    logic                   in_valid_reg;
    logic signed [15:0]     err_reg;
    logic signed [15:0]     vel_reg;
    logic signed [15:0]     dist_reg;

    logic                   out_valid_reg;
    logic                   rising_en_reg;
    logic                   falling_en_reg;
    logic                   settle_en_reg;

    logic [7:0]             rising_count_reg;
    logic [7:0]             falling_count_reg;
    logic [7:0]             settle_count_reg;
    logic [7:0]             rising_count_next;
    logic [7:0]             falling_count_next;
    logic [7:0]             settle_count_next;

    fssd_pkg::fssd_status_t status_reg;
    fssd_pkg::fssd_status_t status_next;

    fssd_pkg::fssd_cond_t   cond;
    logic                   out_load;
    logic                   advance;
    logic                   in_load;
    logic                   en_r;
    logic                   en_f;
    logic                   en_s;

    // Handshake: output register frees up, input register moves on
    assign out_load = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_load;
    assign in_stall = in_valid_reg && !out_load;
    assign in_load  = in_valid && !in_stall;

    // Configuration registers; writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg      <= '0;
            set_delay_reg   <= '0;
            reset_delay_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fssd_pkg::CFG_NULL_ERROR_THRESHOLD:
                    thresh_reg.null_error_threshold <= cfg_data;
                fssd_pkg::CFG_STILL_VELOCITY_THRESHOLD:
                    thresh_reg.still_velocity_threshold <= cfg_data[14:0];
                fssd_pkg::CFG_HOME_BAND_UPPER:
                    thresh_reg.home_band_upper <= cfg_data;
                fssd_pkg::CFG_HOME_BAND_LOWER:
                    thresh_reg.home_band_lower <= cfg_data;
                fssd_pkg::CFG_STICK_ERROR_THRESHOLD:
                    thresh_reg.stick_error_threshold <= cfg_data;
                fssd_pkg::CFG_SET_DELAY_TICKS:
                    set_delay_reg <= cfg_data[7:0];
                fssd_pkg::CFG_RESET_DELAY_TICKS:
                    reset_delay_reg <= cfg_data[7:0];
                default:
                    ;
            endcase
        end
    end

    // Input register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register: sample payload
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            err_reg  <= position_error;
            vel_reg  <= estimated_velocity;
            dist_reg <= home_distance;
        end
    end

    fssd_cond u_cond
    (
        .position_error     (err_reg),
        .estimated_velocity (vel_reg),
        .home_distance      (dist_reg),
        .thresh             (thresh_reg),
        .cond               (cond)
    );

    // Countdowns: reload while false, count down to zero while true
    always_comb
    begin
        if (!cond.rising)
        begin
            rising_count_next = set_delay_reg;
        end
        else if (rising_count_reg != 8'd0)
        begin
            rising_count_next = rising_count_reg - 8'd1;
        end
        else
        begin
            rising_count_next = 8'd0;
        end

        if (!cond.falling)
        begin
            falling_count_next = set_delay_reg;
        end
        else if (falling_count_reg != 8'd0)
        begin
            falling_count_next = falling_count_reg - 8'd1;
        end
        else
        begin
            falling_count_next = 8'd0;
        end

        if (!cond.settled)
        begin
            settle_count_next = reset_delay_reg;
        end
        else if (settle_count_reg != 8'd0)
        begin
            settle_count_next = settle_count_reg - 8'd1;
        end
        else
        begin
            settle_count_next = 8'd0;
        end

        en_r = (rising_count_next == 8'd0);
        en_f = (falling_count_next == 8'd0);
        en_s = (settle_count_next == 8'd0);
    end

    // Status next state from this sample's enables
    always_comb
    begin
        status_next = status_reg;
        case (status_reg)
            fssd_pkg::ST_ADHERE:
            begin
                if (en_r)
                begin
                    status_next = fssd_pkg::ST_RISING;
                end
                else if (en_f)
                begin
                    status_next = fssd_pkg::ST_FALLING;
                end
            end
            fssd_pkg::ST_RISING:
            begin
                if (en_s || en_f)
                begin
                    status_next = fssd_pkg::ST_ADHERE;
                end
            end
            fssd_pkg::ST_FALLING:
            begin
                if (en_s || en_r)
                begin
                    status_next = fssd_pkg::ST_ADHERE;
                end
            end
            default:
            begin
                status_next = fssd_pkg::ST_ADHERE;
            end
        endcase
    end

    // Status and counters advance with each delivered sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg        <= fssd_pkg::ST_ADHERE;
            rising_count_reg  <= '0;
            falling_count_reg <= '0;
            settle_count_reg  <= '0;
        end
        else if (advance)
        begin
            status_reg        <= status_next;
            rising_count_reg  <= rising_count_next;
            falling_count_reg <= falling_count_next;
            settle_count_reg  <= settle_count_next;
        end
    end

    // Output register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Output register: result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rising_en_reg  <= en_r;
            falling_en_reg <= en_f;
            settle_en_reg  <= en_s;
        end
    end

    assign out_valid      = out_valid_reg;
    assign stick_status   = status_reg;
    assign rising_enable  = rising_en_reg;
    assign falling_enable = falling_en_reg;
    assign settle_enable  = settle_en_reg;

endmodule

[tb/tb_friction_stick_status_detector_unit.sv]
// Self-checking testbench for friction_stick_status_detector_unit.
// Drives samples and register writes, predicts every status word in a local
// model of the detector and compares each word taken. Depends on fssd_pkg.
`timescale 1ns / 1ps

module tb_friction_stick_status_detector_unit;

    localparam logic [fssd_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RESET_ROWS     = 4;

    // One result word of the detector
    typedef struct packed {
        logic [1:0] status;
        logic       rise_en;
        logic       fall_en;
        logic       settle_en;
    } detector_word_t;

    // Raw write data for all seven registers
    typedef struct packed {
        logic [15:0] null_thr;
        logic [15:0] still_thr;
        logic [15:0] band_hi;
        logic [15:0] band_lo;
        logic [15:0] stick_thr;
        logic [15:0] set_dly;
        logic [15:0] settle_dly;
    } reg_image_t;

    // Directed sample, with a typed-in result where typed is set
    typedef struct packed {
        logic signed [15:0] err;
        logic signed [15:0] vel;
        logic signed [15:0] hdist;
        logic               typed;
        detector_word_t     want;
    } dir_row_t;

    typedef enum int {
        BURST_RISE,
        BURST_FALL,
        BURST_SETTLE,
        BURST_NOISE
    } burst_kind_t;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic signed [15:0]               position_error;
    logic signed [15:0]               estimated_velocity;
    logic signed [15:0]               home_distance;
    logic                             out_valid;
    logic                             out_stall;
    logic [1:0]                       stick_status;
    logic                             rising_enable;
    logic                             falling_enable;
    logic                             settle_enable;
    logic                             cfg_we;
    logic [fssd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [fssd_pkg::CFG_DATA_W-1:0]  cfg_data;

    // Local copy of configuration and detector state
    int                     null_thr;
    int                     still_thr;
    int                     band_hi;
    int                     band_lo;
    int                     stick_thr;
    int                     set_dly;
    int                     settle_dly;
    fssd_pkg::fssd_status_t status_q;
    int                     rise_cnt;
    int                     fall_cnt;
    int                     settle_cnt;

    detector_word_t pending_words[$];
    dir_row_t       dir_rows[$];
    int             error_count;
    int             idle_cycles;
    bit             calm;

    friction_stick_status_detector_unit u_top
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .position_error     (position_error),
        .estimated_velocity (estimated_velocity),
        .home_distance      (home_distance),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .stick_status       (stick_status),
        .rising_enable      (rising_enable),
        .falling_enable     (falling_enable),
        .settle_enable      (settle_enable),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(99, 0) < 22);
    endfunction

    function automatic int magnitude(input int x);
        return (x < 0) ? -x : x;
    endfunction

    // Reload while the condition is false, else count down and hold at zero
    function automatic int countdown(input int cnt, input bit cond, input int reload);
        if (!cond)
            return reload;
        return (cnt > 0) ? cnt - 1 : 0;
    endfunction

    // Mirror a register write; out-of-range indexes are dropped
    function automatic void apply_register(input logic [fssd_pkg::CFG_INDEX_W-1:0] idx,
                                           input logic [15:0] data);
        case (idx)
            fssd_pkg::CFG_NULL_ERROR_THRESHOLD:     null_thr   = int'(data);
            fssd_pkg::CFG_STILL_VELOCITY_THRESHOLD: still_thr  = int'(data[14:0]);
            fssd_pkg::CFG_HOME_BAND_UPPER:          band_hi    = int'(data);
            fssd_pkg::CFG_HOME_BAND_LOWER:          band_lo    = int'(data);
            fssd_pkg::CFG_STICK_ERROR_THRESHOLD:    stick_thr  = int'(data);
            fssd_pkg::CFG_SET_DELAY_TICKS:          set_dly    = int'(data[7:0]);
            fssd_pkg::CFG_RESET_DELAY_TICKS:        settle_dly = int'(data[7:0]);
            default: ;
        endcase
    endfunction

    // Advance the detector by one sample and return its status word
    function automatic detector_word_t step_detector(input logic signed [15:0] err,
                                                     input logic signed [15:0] vel,
                                                     input logic signed [15:0] hdist);
        int             e;
        int             v;
        int             d;
        bit             settled;
        bit             qualify;
        bit             en_r;
        bit             en_f;
        bit             en_s;
        detector_word_t w;
        e = err;
        v = vel;
        d = hdist;
        settled = magnitude(e) < null_thr;
        qualify = (magnitude(v) < still_thr) && ((d > band_hi) || (d < -band_lo));
        rise_cnt   = countdown(rise_cnt, qualify && (e > stick_thr), set_dly);
        fall_cnt   = countdown(fall_cnt, qualify && (e < -stick_thr), set_dly);
        settle_cnt = countdown(settle_cnt, settled, settle_dly);
        en_r = (rise_cnt == 0);
        en_f = (fall_cnt == 0);
        en_s = (settle_cnt == 0);
        case (status_q)
            fssd_pkg::ST_ADHERE:
            begin
                if (en_r)
                    status_q = fssd_pkg::ST_RISING;
                else if (en_f)
                    status_q = fssd_pkg::ST_FALLING;
            end
            fssd_pkg::ST_RISING:
            begin
                if (en_s || en_f)
                    status_q = fssd_pkg::ST_ADHERE;
            end
            fssd_pkg::ST_FALLING:
            begin
                if (en_s || en_r)
                    status_q = fssd_pkg::ST_ADHERE;
            end
            default: status_q = fssd_pkg::ST_ADHERE;
        endcase
        w.status    = status_q;
        w.rise_en   = en_r;
        w.fall_en   = en_f;
        w.settle_en = en_s;
        return w;
    endfunction

    // Uniform value in [lo, hi] clipped to 16 bits; any value if empty
    function automatic logic signed [15:0] pick(input int lo, input int hi);
        int lo_c;
        int hi_c;
        int val;
        lo_c = (lo < -32768) ? -32768 : lo;
        hi_c = (hi > 32767) ? 32767 : hi;
        if (lo_c > hi_c)
            return 16'($urandom);
        val = lo_c + int'($urandom_range(hi_c - lo_c, 0));
        return val[15:0];
    endfunction

    function automatic logic signed [15:0] outside_band();
        if ($urandom_range(1, 0) == 1)
            return pick(band_hi + 1, 32767);
        return pick(-32768, -band_lo - 1);
    endfunction

    function automatic reg_image_t random_image();
        reg_image_t img;
        img.null_thr   = 16'($urandom_range(2000, 0));
        img.still_thr  = {$urandom_range(1, 0) == 1, 15'($urandom_range(4000, 0))};
        img.band_hi    = 16'($urandom_range(20000, 0));
        img.band_lo    = 16'($urandom_range(20000, 0));
        img.stick_thr  = 16'($urandom_range(10000, 0));
        img.set_dly    = {8'($urandom), 8'($urandom_range(12, 0))};
        img.settle_dly = {8'($urandom), 8'($urandom_range(12, 0))};
        return img;
    endfunction

    function automatic dir_row_t plain_row(input logic signed [15:0] e,
                                           input logic signed [15:0] v,
                                           input logic signed [15:0] d);
        dir_row_t r;
        r.err   = e;
        r.vel   = v;
        r.hdist = d;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    // With all registers at reset every count sits at zero: all enables high
    function automatic dir_row_t typed_row(input logic signed [15:0] e,
                                           input logic signed [15:0] v,
                                           input logic signed [15:0] d,
                                           input fssd_pkg::fssd_status_t st);
        dir_row_t r;
        r = plain_row(e, v, d);
        r.typed = 1'b1;
        r.want  = {st, 1'b1, 1'b1, 1'b1};
        return r;
    endfunction

    // Present one word, hold it until taken, then queue its expected result
    task automatic send_sample(input logic signed [15:0] e,
                               input logic signed [15:0] v,
                               input logic signed [15:0] d,
                               input logic typed,
                               input detector_word_t want);
        detector_word_t w;
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid           <= 1'b1;
        position_error     <= e;
        estimated_velocity <= v;
        home_distance      <= d;
        do
            @(posedge clk);
        while (in_stall);
        w = step_detector(e, v, d);
        pending_words.push_back(typed ? want : w);
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected word has arrived
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [fssd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_register(idx, data);
        @(negedge clk);
    endtask

    // Write every register, plus one write to an unused index
    task automatic load_registers(input reg_image_t img);
        write_reg(fssd_pkg::CFG_NULL_ERROR_THRESHOLD, img.null_thr);
        write_reg(fssd_pkg::CFG_STILL_VELOCITY_THRESHOLD, img.still_thr);
        write_reg(fssd_pkg::CFG_HOME_BAND_UPPER, img.band_hi);
        write_reg(fssd_pkg::CFG_HOME_BAND_LOWER, img.band_lo);
        write_reg(fssd_pkg::CFG_STICK_ERROR_THRESHOLD, img.stick_thr);
        write_reg(fssd_pkg::CFG_SET_DELAY_TICKS, img.set_dly);
        write_reg(fssd_pkg::CFG_RESET_DELAY_TICKS, img.settle_dly);
        write_reg(CFG_UNUSED_INDEX, 16'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Stick, settle and noise sample bursts, most long enough to run counts out
    task automatic run_random_phase(input reg_image_t img, input int n_items);
        int                 sent;
        int                 len;
        int                 k;
        int                 max_dly;
        burst_kind_t        kind;
        int                 roll;
        logic signed [15:0] e;
        logic signed [15:0] v;
        logic signed [15:0] d;
        drain_results();
        load_registers(img);
        sent = 0;
        while (sent < n_items)
        begin
            roll = $urandom_range(99, 0);
            if (roll < 30)
                kind = BURST_RISE;
            else if (roll < 60)
                kind = BURST_FALL;
            else if (roll < 85)
                kind = BURST_SETTLE;
            else
                kind = BURST_NOISE;
            max_dly = (set_dly > settle_dly) ? set_dly : settle_dly;
            if ($urandom_range(9, 0) < 6)
                len = max_dly + 1 + $urandom_range(4, 0);
            else
                len = $urandom_range(max_dly + 4, 1);
            for (k = 0; k < len && sent < n_items; k++)
            begin
                e = 16'($urandom);
                v = 16'($urandom);
                d = 16'($urandom);
                case (kind)
                    BURST_RISE:
                    begin
                        e = pick(stick_thr + 1, 32767);
                        v = pick(1 - still_thr, still_thr - 1);
                        d = outside_band();
                    end
                    BURST_FALL:
                    begin
                        e = pick(-32768, -stick_thr - 1);
                        v = pick(1 - still_thr, still_thr - 1);
                        d = outside_band();
                    end
                    BURST_SETTLE: e = pick(1 - null_thr, null_thr - 1);
                    default: ;
                endcase
                send_sample(e, v, d, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Compare each word taken with the oldest expectation
    always @(posedge clk)
    begin
        detector_word_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_words.size() == 0)
                begin
                    $display("%0t: unexpected word status %0d en %b%b%b", $time,
                             stick_status, rising_enable, falling_enable, settle_enable);
                    error_count++;
                end
                else
                begin
                    want = pending_words.pop_front();
                    if (stick_status !== want.status)
                    begin
                        $display("%0t: stick_status expected %0d actual %0d", $time,
                                 want.status, stick_status);
                        error_count++;
                    end
                    if (rising_enable !== want.rise_en)
                    begin
                        $display("%0t: rising_enable expected %0b actual %0b", $time,
                                 want.rise_en, rising_enable);
                        error_count++;
                    end
                    if (falling_enable !== want.fall_en)
                    begin
                        $display("%0t: falling_enable expected %0b actual %0b", $time,
                                 want.fall_en, falling_enable);
                        error_count++;
                    end
                    if (settle_enable !== want.settle_en)
                    begin
                        $display("%0t: settle_enable expected %0b actual %0b", $time,
                                 want.settle_en, settle_enable);
                        error_count++;
                    end
                end
            end
            // Watchdog: count cycles in which no word moves on either channel
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_friction_stick_status_detector_unit: errors");
                $finish;
            end
        end
    end

    // Random stall on the output side
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= take_break();
        end
    end

    initial
    begin
        reg_image_t directed_img;
        reg_image_t zero_img;
        reg_image_t max_img;
        reg_image_t edge_img;
        reg_image_t long_img;
        int         i;

        rst_n              = 1'b0;
        in_valid           = 1'b0;
        position_error     = '0;
        estimated_velocity = '0;
        home_distance      = '0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        error_count        = 0;
        idle_cycles        = 0;
        calm               = 1'b0;
        null_thr   = 0;
        still_thr  = 0;
        band_hi    = 0;
        band_lo    = 0;
        stick_thr  = 0;
        set_dly    = 0;
        settle_dly = 0;
        status_q   = fssd_pkg::ST_ADHERE;
        rise_cnt   = 0;
        fall_cnt   = 0;
        settle_cnt = 0;

        directed_img = {16'd100, 16'd500, 16'd1000, 16'd1000, 16'd200, 16'd2, 16'd3};
        zero_img     = '0;
        max_img      = '1;
        edge_img     = {16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001, 16'hFF00};
        long_img     = {16'd300, 16'h87D0, 16'd5000, 16'd5000, 16'd400, 16'h00FF, 16'hFFFF};

        // Reset registers: status toggles adhere/rising with every enable high
        dir_rows.push_back(typed_row(16'sh7FFF, 16'sh8000, 16'sh0000, fssd_pkg::ST_RISING));
        dir_rows.push_back(typed_row(16'sh8000, 16'sh7FFF, 16'sh8000, fssd_pkg::ST_ADHERE));
        dir_rows.push_back(typed_row(16'sh0000, 16'sh0000, 16'sh7FFF, fssd_pkg::ST_RISING));
        dir_rows.push_back(typed_row(16'shFFFF, 16'shFFFF, 16'shFFFF, fssd_pkg::ST_ADHERE));
        // Reload all counts, then reach rising stick
        dir_rows.push_back(plain_row(16'sd150, 16'sd0, 16'sd0));
        repeat (3) dir_rows.push_back(plain_row(16'sd300, 16'sd0, 16'sd2000));
        // Settle back to adhere
        dir_rows.push_back(plain_row(16'sd0, 16'sd0, 16'sd0));
        dir_rows.push_back(plain_row(16'sd99, 16'sd0, 16'sd0));
        dir_rows.push_back(plain_row(-16'sd99, 16'sd0, 16'sd0));
        // Falling stick, then leave it through the rising enable
        repeat (3) dir_rows.push_back(plain_row(-16'sd300, 16'sd499, -16'sd2000));
        repeat (3) dir_rows.push_back(plain_row(16'sd300, -16'sd499, 16'sd1001));
        // Boundaries of every compare
        dir_rows.push_back(plain_row(16'sd200, 16'sd0, 16'sd2000));
        dir_rows.push_back(plain_row(-16'sd200, 16'sd0, 16'sd2000));
        dir_rows.push_back(plain_row(16'sd300, 16'sd500, 16'sd2000));
        dir_rows.push_back(plain_row(16'sd300, 16'sd0, 16'sd1000));
        dir_rows.push_back(plain_row(-16'sd300, 16'sd0, -16'sd1000));
        dir_rows.push_back(plain_row(16'sh8000, 16'sh8000, 16'sh8000));
        dir_rows.push_back(plain_row(16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
        dir_rows.push_back(plain_row(16'sd100, 16'sd0, 16'sd0));
        dir_rows.push_back(plain_row(-16'sd100, 16'sd0, 16'sd0));

        // Hold reset low, then release it
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        for (i = 0; i < dir_rows.size(); i++)
        begin
            if (i == RESET_ROWS)
            begin
                drain_results();
                load_registers(directed_img);
            end
            send_sample(dir_rows[i].err, dir_rows[i].vel, dir_rows[i].hdist,
                        dir_rows[i].typed, dir_rows[i].want);
        end

        // Random phases over several register settings
        run_random_phase(zero_img, 60);
        run_random_phase(max_img, 60);
        calm = 1'b1;
        run_random_phase(random_image(), 80);
        calm = 1'b0;
        run_random_phase(edge_img, 60);
        run_random_phase(long_img, 260);
        repeat (4) run_random_phase(random_image(), 70);

        drain_results();
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("tb_friction_stick_status_detector_unit: clean");
        else
            $display("tb_friction_stick_status_detector_unit: errors");
        $finish;
    end

endmodule

[filelist.f]
sv/fssd_pkg.sv
sv/fssd_cond.sv
sv/friction_stick_status_detector_unit.sv
tb/tb_friction_stick_status_detector_unit.sv
